[hw/rtl/sinrr_pkg.sv]
`timescale 1ns / 1ps

package sinrr_pkg;

    // Range reduction constants, unsigned fixed point with 32 fraction bits.
    localparam logic [29:0] INV_TAU_Q32  = 30'd683565275;
    localparam logic [34:0] TAU_Q32      = 35'd26986075409;
    localparam logic [31:0] INV_PIO2_Q32 = 32'd2734261102;

    // Quarter turn with 30 fraction bits, used for the reflection.
    localparam logic [30:0] PIO2_Q30 = 31'd1686629713;

    // Offsets subtracted for quadrants zero to three: q times pi/2 in Q.32.
    localparam logic [34:0] QUAD_OFF_Q32 [4] = '{
        35'd0, 35'd6746518852, 35'd13493037704, 35'd20239556556
    };

    // Odd polynomial coefficients in Q.32, highest order first.
    localparam logic signed [31:0] POLY_Q32 [5] = '{
        -32'sd105, 32'sd11832, -32'sd852174, 32'sd35791394, -32'sd715827883
    };

    // Reduced item passed from the front end to the polynomial back end.
    typedef struct packed {
        logic [31:0] x;     // reduced magnitude, Q.30
        logic        neg;   // sign of the final result
    } t_mid;

endpackage

[hw/rtl/sine_range_reduce_polynomial.sv]
// Pipeline: 7 front stages, a queue write, 11 back stages and the output queue
//   write lie between the edge that accepts an item and its result on o_sine.
// Throughput: one item per clock while no full queue stalls it; every stage of
//   both pipelines then takes a new item; each multiply unit is used once per item.
// Reset: synchronous, active low; clears all valid bits and queue pointers, so
//   empty is high and full is low after reset. Data registers are not reset.
`timescale 1ns / 1ps

module sine_range_reduce_polynomial #(
    parameter int ANGLE_FRAC_BITS = 24,
    parameter int OUT_FRAC_BITS   = 30,
    parameter int QUEUE_DEPTH     = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_angle,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_sine
);

    // The output queue holds two results; the back end stalls on its full
    // flag, which is decoded from the registered count.
    localparam int OUT_DEPTH = 2;

    sinrr_pkg::t_mid    w_front_mid;
    sinrr_pkg::t_mid    w_back_mid;
    logic               w_mid_push;
    logic               w_mid_full;
    logic               w_mid_pop;
    logic               w_mid_empty;
    logic               w_out_push;
    logic signed [31:0] w_out_data;
    logic               w_out_full;

    // Front end: takes the sign off, reduces the angle modulo a full turn,
    // finds the quadrant and reflects the remainder. Each item leaves it as
    // a magnitude in Q.30 and the sign of the final result.
    sinrr_front #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_angle    (i_angle),
        .o_mid_push (w_mid_push),
        .o_mid      (w_front_mid),
        .i_mid_full (w_mid_full)
    );

    // The queue between the two halves lets either side stall without
    // holding up the other.
    sinrr_fifo #(
        .WIDTH ($bits(sinrr_pkg::t_mid)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_front_mid),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_empty (w_mid_empty),
        .o_data  (w_back_mid)
    );

    // Back end: odd degree-11 polynomial by Horner's rule, multiply stages alternating
    // with add stages, followed by clamping, scaling, saturation and the sign.
    sinrr_back #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (w_mid_empty),
        .i_mid       (w_back_mid),
        .o_mid_pop   (w_mid_pop),
        .o_out_push  (w_out_push),
        .o_out_data  (w_out_data),
        .i_out_full  (w_out_full)
    );

    // Finished results wait here until the consumer pops them.
    sinrr_fifo #(
        .WIDTH (32),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_data),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_sine)
    );

endmodule

[hw/rtl/sinrr_fifo.sv]
`timescale 1ns / 1ps

module sinrr_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wp;
    logic [PTR_W-1:0] n_rp;
    logic [CNT_W-1:0] n_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_rd) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        case ({w_wr, w_rd})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[hw/rtl/sinrr_front.sv]
`timescale 1ns / 1ps

module sinrr_front #(
    parameter int ANGLE_FRAC_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic signed [31:0]     i_angle,
    output logic                   o_mid_push,
    output sinrr_pkg::t_mid        o_mid,
    input  logic                   i_mid_full
);

    localparam int A_SH  = 32 - ANGLE_FRAC_BITS;
    localparam int A_W   = 32 + A_SH;
    localparam int P1_W  = A_W + 14;
    localparam int K_W   = P1_W - 48;
    localparam int KT_W  = A_W + 1;
    localparam int NSTG  = 7;

    logic [NSTG-1:0] r_vld;
    logic            w_en;

    // Stage registers, numbered by pipeline stage.
    logic [A_W-1:0]  r_a0, r_a1, r_a2;
    logic            r_neg0, r_neg1, r_neg2, r_neg3, r_neg4, r_neg5, r_neg6;
    logic [K_W-1:0]  r_k1;
    logic [KT_W-1:0] r_kt2;
    logic [36:0]     r_r03;
    logic [34:0]     r_r4, r_r5;
    logic [1:0]      r_q5;
    logic [31:0]     r_x6;

    logic [A_W-1:0]  n_a0;
    logic            n_neg0;
    logic [K_W-1:0]  n_k1;
    logic [KT_W-1:0] n_kt2;
    logic [36:0]     n_r03;
    logic [34:0]     n_r4;
    logic [1:0]      n_q5;
    logic [31:0]     n_x6;
    logic            n_neg6;

    logic [31:0]        w_raw;
    logic [31:0]        w_mag;
    logic [P1_W-1:0]    w_p1;
    logic [KT_W-1:0]    w_diff;
    logic [62:0]        w_p5;
    logic [2:0]         w_q3;
    logic [34:0]        w_m;
    logic [32:0]        w_xq;
    logic signed [33:0] w_dv;
    logic [33:0]        w_dmag;

    // The pipeline moves whenever its last stage is free or can hand off.
    assign w_en       = !r_vld[NSTG-1] || !i_mid_full;
    assign o_full     = !w_en;
    assign o_mid_push = r_vld[NSTG-1] && !i_mid_full;
    assign o_mid.x    = r_x6;
    assign o_mid.neg  = r_neg6;

    always_comb begin
        // Sign split; the most negative angle gives 2^31, which fits unsigned.
        w_raw  = i_angle;
        n_neg0 = w_raw[31];
        w_mag  = w_raw[31] ? (~w_raw + 32'd1) : w_raw;
        n_a0   = {w_mag, {A_SH{1'b0}}};

        // Turn count from a truncated product with 1/tau.
        w_p1 = P1_W'(r_a0[A_W-1:16]) * P1_W'(sinrr_pkg::INV_TAU_Q32);
        n_k1 = w_p1[P1_W-1:48];

        n_kt2 = KT_W'(r_k1) * KT_W'(sinrr_pkg::TAU_Q32);

        // The turn count never overshoots, so the difference stays small.
        w_diff = {1'b0, r_a2} - r_kt2;
        n_r03  = w_diff[36:0];

        n_r4 = (r_r03 >= 37'(sinrr_pkg::TAU_Q32))
             ? 35'(r_r03 - 37'(sinrr_pkg::TAU_Q32)) : r_r03[34:0];

        // Quadrant from a truncated product with 2/pi, clamped to three.
        w_p5 = 63'(r_r4[34:4]) * 63'(sinrr_pkg::INV_PIO2_Q32);
        w_q3 = w_p5[62:60];
        n_q5 = w_q3[2] ? 2'd3 : w_q3[1:0];

        // Remainder inside the quadrant, reflected in odd quadrants.
        w_m  = r_r5 - sinrr_pkg::QUAD_OFF_Q32[r_q5];
        w_xq = w_m[34:2];
        if (r_q5[0]) begin
            w_dv = $signed(34'(sinrr_pkg::PIO2_Q30)) - $signed({1'b0, w_xq});
        end else begin
            w_dv = $signed({1'b0, w_xq});
        end
        w_dmag = w_dv[33] ? (~w_dv + 34'd1) : w_dv;
        n_x6   = w_dmag[31:0];
        // The polynomial is odd, so a negative reflection flips the sign.
        n_neg6 = r_neg5 ^ r_q5[1] ^ w_dv[33];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a0   <= n_a0;
            r_neg0 <= n_neg0;
            r_a1   <= r_a0;
            r_k1   <= n_k1;
            r_neg1 <= r_neg0;
            r_a2   <= r_a1;
            r_kt2  <= n_kt2;
            r_neg2 <= r_neg1;
            r_r03  <= n_r03;
            r_neg3 <= r_neg2;
            r_r4   <= n_r4;
            r_neg4 <= r_neg3;
            r_r5   <= r_r4;
            r_q5   <= n_q5;
            r_neg5 <= r_neg4;
            r_x6   <= n_x6;
            r_neg6 <= n_neg6;
        end
    end

endmodule

[hw/rtl/sinrr_back.sv]
`timescale 1ns / 1ps

module sinrr_back #(
    parameter int OUT_FRAC_BITS = 30
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_mid_empty,
    input  sinrr_pkg::t_mid    i_mid,
    output logic               o_mid_pop,
    output logic               o_out_push,
    output logic signed [31:0] o_out_data,
    input  logic               i_out_full
);

    localparam int BK_N   = 11;
    localparam int OUT_SH = 30 - OUT_FRAC_BITS;

    typedef struct packed {
        logic [31:0]        x;
        logic               neg;
        logic [33:0]        x2;
        logic [32:0]        t;
        logic signed [31:0] p;
        logic [35:0]        prod;
        logic               prod_neg;
        logic signed [34:0] y;
    } t_bk_st;

    t_bk_st          r_bk [BK_N];
    t_bk_st          n_bk [BK_N];
    logic [BK_N-1:0] r_bv;
    logic            w_en;

    logic [63:0]        w_xx;
    logic [65:0]        w_tm;
    logic [31:0]        w_hmag [1:4];
    logic [65:0]        w_hmul [1:4];
    logic signed [36:0] w_hsp  [1:4];
    logic signed [36:0] w_hadd [1:4];
    logic [31:0]        w_fmag;
    logic [64:0]        w_fmul;
    logic signed [34:0] w_fsp;
    logic [33:0]        w_yc;
    logic [33:0]        w_u;
    logic [33:0]        w_us;
    logic [33:0]        w_res;

    assign w_en       = !r_bv[BK_N-1] || !i_out_full;
    assign o_mid_pop  = w_en && !i_mid_empty;
    assign o_out_push = r_bv[BK_N-1] && !i_out_full;

    assign w_xx = 64'(i_mid.x) * 64'(i_mid.x);
    assign w_tm = 66'(r_bk[0].x2) * 66'(r_bk[0].x);

    // Horner steps: a multiply stage, then a negate and add stage.
    for (genvar gi = 1; gi <= 4; gi++) begin : g_horner
        assign w_hmag[gi] = r_bk[2*gi-2].p[31] ? (~r_bk[2*gi-2].p + 32'd1)
                                              : r_bk[2*gi-2].p;
        assign w_hmul[gi] = 66'(w_hmag[gi]) * 66'(r_bk[2*gi-2].x2);
        assign w_hsp[gi]  = $signed({1'b0, r_bk[2*gi-1].prod});
        assign w_hadd[gi] = (r_bk[2*gi-1].prod_neg ? -w_hsp[gi] : w_hsp[gi])
                          + 37'(sinrr_pkg::POLY_Q32[gi]);
    end

    assign w_fmag = r_bk[8].p[31] ? (~r_bk[8].p + 32'd1) : r_bk[8].p;
    assign w_fmul = 65'(w_fmag) * 65'(r_bk[8].t);
    assign w_fsp  = $signed({1'b0, r_bk[9].prod[33:0]});

    always_comb begin
        for (int s = 1; s < BK_N; s++) begin
            n_bk[s] = r_bk[s-1];
        end

        n_bk[0]     = '0;
        n_bk[0].x   = i_mid.x;
        n_bk[0].neg = i_mid.neg;
        n_bk[0].x2  = w_xx[63:30];
        n_bk[0].p   = sinrr_pkg::POLY_Q32[0];

        // Odd term x^3, formed next to the first Horner product.
        n_bk[1].t = w_tm[62:30];

        for (int i = 1; i <= 4; i++) begin
            n_bk[2*i-1].prod     = w_hmul[i][65:30];
            n_bk[2*i-1].prod_neg = r_bk[2*i-2].p[31];
            n_bk[2*i].p          = w_hadd[i][31:0];
        end

        n_bk[9].prod     = 36'(w_fmul[64:32]);
        n_bk[9].prod_neg = r_bk[8].p[31];

        n_bk[10].y = $signed({3'b000, r_bk[9].x})
                   + (r_bk[9].prod_neg ? -w_fsp : w_fsp);
    end

    // Clamp at zero, scale to the output format, saturate at one, apply sign.
    always_comb begin
        w_yc  = r_bk[BK_N-1].y[34] ? 34'd0 : r_bk[BK_N-1].y[33:0];
        w_u   = w_yc >> OUT_SH;
        w_us  = (w_u > (34'd1 << OUT_FRAC_BITS)) ? (34'd1 << OUT_FRAC_BITS) : w_u;
        w_res = r_bk[BK_N-1].neg ? (~w_us + 34'd1) : w_us;
        o_out_data = w_res[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (w_en) begin
            r_bv <= {r_bv[BK_N-2:0], !i_mid_empty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < BK_N; s++) begin
                r_bk[s] <= n_bk[s];
            end
        end
    end

endmodule

[tb/sine_range_reduce_polynomial_test.sv]
`timescale 1ns / 1ps

// Angle and result formats of the block as instantiated here.
localparam int ANGLE_FRAC = 24;
localparam int SINE_FRAC  = 30;

// Range reduction constants, unsigned with 32 fraction bits (pi/2 also with 30).
localparam logic [63:0] INV_TAU_Q32  = 64'd683565275;
localparam logic [63:0] TAU_Q32      = 64'd26986075409;
localparam logic [63:0] INV_PIO2_Q32 = 64'd2734261102;
localparam logic [63:0] PIO2_Q32     = 64'd6746518852;
localparam longint      PIO2_Q30     = 64'sd1686629713;

// Odd polynomial coefficients in Q.32, from the x^11 term down to the x^3 term.
localparam longint SIN_C11 = -64'sd105;
localparam longint SIN_C9  = 64'sd11832;
localparam longint SIN_C7  = -64'sd852174;
localparam longint SIN_C5  = 64'sd35791394;
localparam longint SIN_C3  = -64'sd715827883;

// Keeps the expected sine of every accepted angle, oldest first, and checks the
// results leaving the block against it.
class sine_scoreboard;
    logic signed [31:0] sine_fifo [$];
    int unsigned        angles_in;
    int unsigned        sines_checked;
    int unsigned        saturated;
    int unsigned        mismatches;

    function new();
        angles_in     = 0;
        sines_checked = 0;
        saturated     = 0;
        mismatches    = 0;
    endfunction

    // Product of two signed values, magnitude truncated after the shift.
    function longint mul_trunc(longint a, longint b, int unsigned sh);
        bit          neg_p;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] prod;
        neg_p = (a < 0) != (b < 0);
        ma    = (a < 0) ? 64'(-a) : 64'(a);
        mb    = (b < 0) ? 64'(-b) : 64'(b);
        prod  = (ma * mb) >> sh;
        return neg_p ? -longint'(prod) : longint'(prod);
    endfunction

    function logic signed [31:0] sine_of(logic signed [31:0] angle);
        bit          neg;
        logic [63:0] mag;
        logic [63:0] a;
        logic [63:0] k;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] ux;
        logic [63:0] u;
        logic [63:0] one;
        logic [31:0] res;
        longint      x;
        longint      x2;
        longint      acc;
        longint      t;
        longint      y;
        neg = angle[31];
        mag = neg ? (64'h1_0000_0000 - {32'd0, angle}) : {32'd0, angle};
        a   = mag << (32 - ANGLE_FRAC);
        k   = ((a >> 16) * INV_TAU_Q32) >> 48;
        r   = a - k * TAU_Q32;
        if (r >= TAU_Q32) begin
            r = r - TAU_Q32;
        end
        q = ((r >> 4) * INV_PIO2_Q32) >> 60;
        if (q > 3) begin
            q = 3;
        end
        x = longint'((r - q * PIO2_Q32) >> 2);
        if (q == 1 || q == 3) begin
            x = PIO2_Q30 - x;
        end
        if (q >= 2) begin
            neg = !neg;
        end
        if (x < 0) begin
            x   = -x;
            neg = !neg;
        end
        ux  = x;
        x2  = longint'((ux * ux) >> 30);
        acc = SIN_C11;
        acc = mul_trunc(acc, x2, 30) + SIN_C9;
        acc = mul_trunc(acc, x2, 30) + SIN_C7;
        acc = mul_trunc(acc, x2, 30) + SIN_C5;
        acc = mul_trunc(acc, x2, 30) + SIN_C3;
        t   = longint'((64'(x2) * ux) >> 30);
        y   = x + mul_trunc(acc, t, 32);
        if (y < 0) begin
            y = 0;
        end
        u   = 64'(y) >> (30 - SINE_FRAC);
        one = 64'd1 << SINE_FRAC;
        if (u > one) begin
            u = one;
        end
        res = u[31:0];
        if (neg) begin
            res = -res;
        end
        return res;
    endfunction

    function void note_angle(logic signed [31:0] angle);
        sine_fifo.push_back(sine_of(angle));
        angles_in++;
    endfunction

    function void check_sine(logic signed [31:0] actual);
        logic signed [31:0] expected;
        if (sine_fifo.size() == 0) begin
            $error("sine: result %0d arrived with no angle pending", actual);
            mismatches++;
            return;
        end
        expected = sine_fifo.pop_front();
        sines_checked++;
        if (expected == (32'sd1 <<< SINE_FRAC) || expected == -(32'sd1 <<< SINE_FRAC)) begin
            saturated++;
        end
        if (actual !== expected) begin
            $error("sine: expected %0d, actual %0d", expected, actual);
            mismatches++;
        end
    endfunction

    function int pending();
        return sine_fifo.size();
    endfunction
endclass

module sine_range_reduce_polynomial_test;

    // Angles in Q8.24: pi/4 and the angles that sit on the quadrant and turn boundaries.
    localparam int ANG_PI_4  = 13176795;
    localparam int ANG_PI_2  = 26353589;
    localparam int ANG_PI    = 52707179;
    localparam int ANG_3PI_2 = 79060768;
    localparam int ANG_TAU   = 105414357;

    localparam int ITEMS_PER_PHASE = 667;
    // Idle margin that runs on after the last result has been checked.
    localparam int DRAIN_CYCLES    = 40;
    // Cycles without any accepted item before the run is declared hung.
    localparam int HANG_LIMIT      = 4000;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic signed [31:0] i_angle;
    logic               empty;
    logic               pop;
    logic signed [31:0] o_sine;

    sine_scoreboard sb;

    // Percent of cycles in which each side holds back.
    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;
    int unsigned quiet_cycles;

    sine_range_reduce_polynomial dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_angle (i_angle),
        .empty   (empty),
        .pop     (pop),
        .o_sine  (o_sine)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The receiver pops at random; during reset it may as well, since empty is high.
    initial begin
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            pop <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Both handshakes are sampled at the edge, before any driver update of that
    // edge lands, so the values seen here are the ones the block saw. The same
    // block watches for a hang: a long run of cycles with nothing accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            sb.note_angle(i_angle);
        end
        if (i_rst_n && pop && !empty) begin
            sb.check_sine(o_sine);
        end
        if (i_rst_n && ((push && !full) || (pop && !empty))) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == HANG_LIMIT) begin
            $display("Timed out with %0d results still pending", sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offers one angle and returns at the edge that accepts it. Before the offer
    // the sender may idle for a random number of cycles.
    task automatic send_angle(input logic signed [31:0] angle);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        i_angle <= angle;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
    endtask

    // Random angles: a share across the whole input range, so that every bit
    // toggles, a share within one turn either way, and a share placed a few
    // LSBs off a multiple of pi/2, where quadrant rounding and reflection bite.
    task automatic send_random(input int count);
        int   sel;
        int   mult;
        int   offs;
        logic signed [31:0] angle;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(9);
            if (sel < 4) begin
                angle = $urandom;
            end else if (sel < 7) begin
                angle = int'($urandom_range(0, 2 * ANG_TAU)) - ANG_TAU;
            end else begin
                mult  = $urandom_range(0, 81);
                offs  = int'($urandom_range(0, 64)) - 32;
                angle = mult * ANG_PI_2 + offs;
                if ($urandom_range(1)) begin
                    angle = -angle;
                end
            end
            send_angle(angle);
        end
    endtask

    initial begin
        sb           = new();
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_angle      = '0;
        tx_idle_pct  = 17;
        rx_stall_pct = 52;
        quiet_cycles = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed angles: zero and the smallest steps, both extremes of the
        // input (the most negative one has a magnitude that needs 32 bits), the
        // quadrant boundaries, where the result can saturate to one, and the last
        // angles below a full turn, where the quadrant can round up to four.
        send_angle(32'sd0);
        send_angle(32'sd1);
        send_angle(-32'sd1);
        send_angle(32'sh7FFF_FFFF);
        send_angle(32'sh8000_0000);
        send_angle(32'sh8000_0001);
        send_angle(ANG_PI_4);
        send_angle(ANG_PI_2);
        send_angle(-ANG_PI_2);
        send_angle(ANG_PI_2 + 1);
        send_angle(ANG_PI);
        send_angle(ANG_PI - 1);
        send_angle(-ANG_PI);
        send_angle(ANG_3PI_2);
        send_angle(ANG_3PI_2 + 1);
        send_angle(ANG_TAU - 1);
        send_angle(ANG_TAU);
        send_angle(ANG_TAU + 1);
        send_angle(-ANG_TAU);
        send_angle(32'sh0100_0000);
        send_angle(32'sh5555_5555);
        send_angle(32'shAAAA_AAAA);

        send_random(ITEMS_PER_PHASE - 22);

        // Second mix: a slow sender against an eager receiver.
        tx_idle_pct  = 52;
        rx_stall_pct = 17;
        send_random(ITEMS_PER_PHASE);

        // Last mix: both sides at full rate.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_random(ITEMS_PER_PHASE);
        push <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d angles (boundary cases, full range, near quadrant edges)",
                 sb.angles_in);
        $display("under three idle/stall mixes; %0d sines checked, %0d of them saturated.",
                 sb.sines_checked, sb.saturated);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
